// File: design/rotstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotstg_pkg
// Shared types and constants for the rotating equipment stager.
// ----------------------------------------------------------------------------
package rotstg_pkg;

    // Fixed field widths
    localparam int PTR_W       = 6;
    localparam int HOLD_W      = 16;
    localparam int OIU_W       = 6;
    localparam int START_W     = 5;
    localparam int ACTIVE_W    = 6;
    localparam int ACT_W       = 2;
    localparam int IDX_W       = 5;
    localparam int OUT_ON_W    = 32;
    localparam int REQ_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (OUT_ON_W + ACTIVE_W + ACT_W + IDX_W);

    // Request bit positions in the input beat
    localparam int REQ_STAGE   = 0;
    localparam int REQ_UNSTAGE = 1;
    localparam int REQ_STOP    = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STAGE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNSTAGE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STOP    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_HOLDOFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSTAGE_HOLDOFF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION  = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REDUCE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic eval;
        logic reduce;
        logic scan;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_search;
        logic reduce_done;
        logic scan_end;
    } stat_t;

endpackage

// File: design/rotstg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotstg_ctrl
// Tick sequencer: evaluate, reduce the start pointer, scan, deliver result.
// ----------------------------------------------------------------------------
module rotstg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rotstg_pkg::stat_t stat,
    output rotstg_pkg::cmd_t  cmd
);

    rotstg_pkg::state_t state_reg;
    rotstg_pkg::state_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rotstg_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = rotstg_pkg::ST_EVAL;
            end
            rotstg_pkg::ST_EVAL:
            begin
                if (stat.need_search)
                    state_next = rotstg_pkg::ST_REDUCE;
                else
                    state_next = rotstg_pkg::ST_FINISH;
            end
            rotstg_pkg::ST_REDUCE:
            begin
                if (stat.reduce_done)
                    state_next = rotstg_pkg::ST_SCAN;
            end
            rotstg_pkg::ST_SCAN:
            begin
                if (stat.scan_end)
                    state_next = rotstg_pkg::ST_FINISH;
            end
            rotstg_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = rotstg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rotstg_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rotstg_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            rotstg_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            rotstg_pkg::ST_REDUCE:
            begin
                cmd.reduce = !stat.reduce_done;
            end
            rotstg_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            rotstg_pkg::ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output beat valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rotstg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/rotstg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotstg_datapath
// Configuration, on bits, hold-off counters, pointers and round-robin scan.
// ----------------------------------------------------------------------------
module rotstg_datapath #(
    parameter int MAX_OUTPUTS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rotstg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotstg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [rotstg_pkg::REQ_W-1:0]         in_req,
    input  rotstg_pkg::cmd_t                     cmd,
    output rotstg_pkg::stat_t                    stat,
    output logic [rotstg_pkg::OUT_TDATA_W-1:0]   out_data
);

    localparam int IW = $clog2(MAX_OUTPUTS);
    localparam int CW = $clog2(MAX_OUTPUTS + 1);
    localparam int SW = (CW > rotstg_pkg::PTR_W) ? CW : rotstg_pkg::PTR_W;

    logic [rotstg_pkg::OIU_W-1:0]     oiu_reg, oiu_next;
    logic [rotstg_pkg::HOLD_W-1:0]    stage_hold_reg, stage_hold_next;
    logic [rotstg_pkg::HOLD_W-1:0]    unstage_hold_reg, unstage_hold_next;
    logic [MAX_OUTPUTS-1:0]           on_bits_reg, on_bits_next;
    logic [rotstg_pkg::HOLD_W-1:0]    stage_wait_reg, stage_wait_next;
    logic [rotstg_pkg::HOLD_W-1:0]    unstage_wait_reg, unstage_wait_next;
    logic [rotstg_pkg::PTR_W-1:0]     stage_ptr_reg, stage_ptr_next;
    logic [rotstg_pkg::PTR_W-1:0]     unstage_ptr_reg, unstage_ptr_next;
    logic [rotstg_pkg::ACTIVE_W-1:0]  active_reg, active_next;
    logic [rotstg_pkg::REQ_W-1:0]     req_reg, req_next;
    logic                             want_reg, want_next;
    logic [SW-1:0]                    cur_reg, cur_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [rotstg_pkg::ACT_W-1:0]     act_reg, act_next;
    logic [rotstg_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [rotstg_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [CW-1:0]                    n_eff;
    logic [rotstg_pkg::HOLD_W-1:0]    sw_dec;
    logic [rotstg_pkg::HOLD_W-1:0]    uw_dec;
    logic                             do_stage;
    logic                             do_unstage;
    logic                             hit;
    logic                             last;
    logic [SW-1:0]                    cur_inc;
    logic [63:0]                      on_wide;

    // Effective output count, clamped to 1..MAX_OUTPUTS
    always_comb
    begin
        if (oiu_reg == '0)
            n_eff = CW'(1);
        else if (32'(oiu_reg) > 32'(MAX_OUTPUTS))
            n_eff = CW'(MAX_OUTPUTS);
        else
            n_eff = CW'(oiu_reg);
    end

    assign sw_dec = stage_wait_reg - rotstg_pkg::HOLD_W'(stage_wait_reg != '0);
    assign uw_dec = unstage_wait_reg - rotstg_pkg::HOLD_W'(unstage_wait_reg != '0);

    assign do_stage   = !req_reg[rotstg_pkg::REQ_STOP] && req_reg[rotstg_pkg::REQ_STAGE]
                        && (sw_dec == '0);
    assign do_unstage = !req_reg[rotstg_pkg::REQ_STOP] && !req_reg[rotstg_pkg::REQ_STAGE]
                        && req_reg[rotstg_pkg::REQ_UNSTAGE] && (uw_dec == '0);

    assign hit     = (on_bits_reg[cur_reg[IW-1:0]] == want_reg);
    assign last    = (cnt_reg == n_eff - CW'(1));
    assign cur_inc = cur_reg + SW'(1);
    assign on_wide = 64'(on_bits_reg);

    assign stat.need_search = do_stage || do_unstage;
    assign stat.reduce_done = (cur_reg < SW'(n_eff));
    assign stat.scan_end    = hit || last;

    always_comb
    begin
        oiu_next          = oiu_reg;
        stage_hold_next   = stage_hold_reg;
        unstage_hold_next = unstage_hold_reg;
        on_bits_next      = on_bits_reg;
        stage_wait_next   = stage_wait_reg;
        unstage_wait_next = unstage_wait_reg;
        stage_ptr_next    = stage_ptr_reg;
        unstage_ptr_next  = unstage_ptr_reg;
        active_next       = active_reg;
        req_next          = req_reg;
        want_next         = want_reg;
        cur_next          = cur_reg;
        cnt_next          = cnt_reg;
        act_next          = act_reg;
        idx_next          = idx_reg;
        out_data_next     = out_data_reg;

        // Register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                rotstg_pkg::CFG_OUTPUTS_IN_USE:
                    oiu_next = cfg_data[rotstg_pkg::OIU_W-1:0];
                rotstg_pkg::CFG_STAGE_HOLDOFF:
                    stage_hold_next = cfg_data;
                rotstg_pkg::CFG_UNSTAGE_HOLDOFF:
                    unstage_hold_next = cfg_data;
                rotstg_pkg::CFG_START_POSITION:
                begin
                    stage_ptr_next   = rotstg_pkg::PTR_W'(cfg_data[rotstg_pkg::START_W-1:0]);
                    unstage_ptr_next = rotstg_pkg::PTR_W'(cfg_data[rotstg_pkg::START_W-1:0]);
                end
                default:
                begin
                    oiu_next = oiu_reg;
                end
            endcase
        end

        // Capture the requests of the beat
        if (cmd.accept)
            req_next = in_req;

        // Count down hold-offs and settle stop or pick a search
        if (cmd.eval)
        begin
            stage_wait_next   = sw_dec;
            unstage_wait_next = uw_dec;
            act_next          = rotstg_pkg::ACT_NONE;
            idx_next          = '0;
            cnt_next          = '0;
            want_next         = do_unstage;
            cur_next          = do_stage ? SW'(stage_ptr_reg) : SW'(unstage_ptr_reg);
            if (req_reg[rotstg_pkg::REQ_STOP])
            begin
                if (on_bits_reg != '0)
                    unstage_wait_next = unstage_hold_reg;
                on_bits_next = '0;
                active_next  = '0;
                act_next     = rotstg_pkg::ACT_STOP;
            end
        end

        // Bring the start pointer below the output count
        if (cmd.reduce)
            cur_next = cur_reg - SW'(n_eff);

        // Step the round-robin scan one output
        if (cmd.scan)
        begin
            if (hit)
            begin
                on_bits_next[cur_reg[IW-1:0]] = !want_reg;
                idx_next = cur_reg[rotstg_pkg::IDX_W-1:0];
                if (want_reg)
                begin
                    unstage_wait_next = unstage_hold_reg;
                    unstage_ptr_next  = cur_inc[rotstg_pkg::PTR_W-1:0];
                    active_next       = active_reg - rotstg_pkg::ACTIVE_W'(1);
                    act_next          = rotstg_pkg::ACT_UNSTAGE;
                end
                else
                begin
                    stage_wait_next = stage_hold_reg;
                    stage_ptr_next  = cur_inc[rotstg_pkg::PTR_W-1:0];
                    active_next     = active_reg + rotstg_pkg::ACTIVE_W'(1);
                    act_next        = rotstg_pkg::ACT_STAGE;
                end
            end
            else
            begin
                cnt_next = cnt_reg + CW'(1);
                cur_next = (cur_inc == SW'(n_eff)) ? '0 : cur_inc;
            end
        end

        // Load the result beat
        if (cmd.finish)
            out_data_next = {{rotstg_pkg::OUT_PAD_W{1'b0}}, idx_reg, act_reg, active_reg,
                             on_wide[rotstg_pkg::OUT_ON_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oiu_reg          <= rotstg_pkg::OIU_W'(1);
            stage_hold_reg   <= '0;
            unstage_hold_reg <= '0;
            on_bits_reg      <= '0;
            stage_wait_reg   <= '0;
            unstage_wait_reg <= '0;
            stage_ptr_reg    <= '0;
            unstage_ptr_reg  <= '0;
            active_reg       <= '0;
        end
        else
        begin
            oiu_reg          <= oiu_next;
            stage_hold_reg   <= stage_hold_next;
            unstage_hold_reg <= unstage_hold_next;
            on_bits_reg      <= on_bits_next;
            stage_wait_reg   <= stage_wait_next;
            unstage_wait_reg <= unstage_wait_next;
            stage_ptr_reg    <= stage_ptr_next;
            unstage_ptr_reg  <= unstage_ptr_next;
            active_reg       <= active_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        want_reg     <= want_next;
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        act_reg      <= act_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

// File: design/rotating_equipment_stager_top.sv
`timescale 1ns / 1ps
// Sequence: a tick with no search (stop, hold-off running, no request) goes from the input beat
// through evaluate and finish to the result beat; a search adds the reduce state, which takes the
// outputs in use off the pointer until it is below them, and a scan of at most the outputs in use.
// Throughput: one tick at a time; next beat is taken the cycle after the result loads.
// Reset: all outputs off, hold-offs and pointers zero, one output in use.
// ----------------------------------------------------------------------------
// rotating_equipment_stager_top
// Lead/lag round-robin staging of on/off equipment outputs, one tick per beat.
// ----------------------------------------------------------------------------
module rotating_equipment_stager_top #(
    parameter int MAX_OUTPUTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [rotstg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rotstg_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Tick input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] stage_request, [1] unstage_request, [2] stop_request, [7:3] zero
    input  logic [rotstg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] outputs_on, [37:32] active_count, [39:38] action_taken,
    // [44:40] changed_index, [47:45] zero
    output logic [rotstg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    rotstg_pkg::cmd_t  cmd;
    rotstg_pkg::stat_t stat;

    rotstg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rotstg_datapath #(
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (s_axis_tdata[rotstg_pkg::REQ_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTH
    // One tick in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a tick is in flight");

    // Result loads only into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending beat");

    // Loaded result is presented next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // A stop result shows everything off
    a_stop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[39:38] == rotstg_pkg::ACT_STOP))
        |-> (m_axis_tdata[37:0] == '0))
        else $error("stop result with outputs still on");
`endif

endmodule
